/* rtl/mpd_pkg.sv */
// ----------------------------------------------------------------------------
// mpd_pkg
// Types and constants shared by the packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

    localparam int LEN_W       = 28;
    localparam int IDX_W       = 16;
    localparam int LBC_W       = 3;
    localparam int GROUP_W     = 7;
    localparam int CONT_BIT    = 7;

    localparam logic [LBC_W-1:0] MAX_LENGTH_BYTES   = 3'd4;
    localparam logic [IDX_W-1:0] BUFFER_SIZE_RESET  = 16'd256;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_HEADER  = 2'd0,
        ROLE_LENGTH  = 2'd1,
        ROLE_PAYLOAD = 2'd2
    } role_t;

    typedef struct packed {
        logic [7:0]       byte_value;
        logic [IDX_W-1:0] buffer_index;
        logic             store_enable;
        role_t            byte_role;
        logic [3:0]       packet_type;
        logic [LEN_W-1:0] remaining_length;
        logic [IDX_W-1:0] stored_length;
        logic [LBC_W-1:0] length_field_bytes;
        logic             packet_end;
        logic             framing_error;
    } result_t;

endpackage

`default_nettype wire

/* rtl/mpd_in_stage.sv */
// ----------------------------------------------------------------------------
// mpd_in_stage
// Input register for received bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    output logic            byte_valid,
    output logic [7:0]      byte_data,
    input  wire logic       advance
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/mpd_core.sv */
// ----------------------------------------------------------------------------
// mpd_core
// Framing state and per-byte decode of header, length varint and payload.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_core (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     advance,
    input  wire logic [7:0]               rx_byte,
    input  wire logic [mpd_pkg::IDX_W-1:0] buffer_size,
    output mpd_pkg::result_t              result
);

    mpd_pkg::phase_t               phase_reg;
    mpd_pkg::phase_t               phase_next;
    logic [mpd_pkg::IDX_W-1:0]     stored_count_reg;
    logic [mpd_pkg::IDX_W-1:0]     stored_count_next;
    logic [mpd_pkg::LEN_W-1:0]     acc_reg;
    logic [mpd_pkg::LEN_W-1:0]     acc_next;
    logic [mpd_pkg::LBC_W-1:0]     lbc_reg;
    logic [mpd_pkg::LBC_W-1:0]     lbc_next;
    logic [mpd_pkg::LEN_W-1:0]     payload_left_reg;
    logic [mpd_pkg::LEN_W-1:0]     payload_left_next;
    logic [3:0]                    type_reg;
    logic [3:0]                    type_next;
    logic [mpd_pkg::LEN_W-1:0]     group_shifted;
    logic [mpd_pkg::GROUP_W-1:0]   group;
    logic [mpd_pkg::IDX_W-1:0]     count_inc;

    assign group     = rx_byte[mpd_pkg::GROUP_W-1:0];
    assign count_inc = stored_count_reg + 16'd1;

    // 7-bit group placed by the number of length bytes already seen
    always_comb
    begin
        unique case (lbc_reg[1:0])
            2'd0:    group_shifted = {21'd0, group};
            2'd1:    group_shifted = {14'd0, group, 7'd0};
            2'd2:    group_shifted = {7'd0, group, 14'd0};
            default: group_shifted = {group, 21'd0};
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        stored_count_next = stored_count_reg;
        acc_next          = acc_reg;
        lbc_next          = lbc_reg;
        payload_left_next = payload_left_reg;
        type_next         = type_reg;

        result                = '0;
        result.byte_value     = rx_byte;
        result.byte_role      = mpd_pkg::ROLE_HEADER;

        unique case (phase_reg)
            mpd_pkg::PH_LENGTH:
            begin
                result.byte_role    = mpd_pkg::ROLE_LENGTH;
                result.store_enable = 1'b1;
                result.buffer_index = stored_count_reg;
                stored_count_next   = count_inc;
                acc_next            = acc_reg + group_shifted;
                lbc_next            = lbc_reg + 3'd1;
                if (rx_byte[mpd_pkg::CONT_BIT])
                begin
                    if (lbc_next >= mpd_pkg::MAX_LENGTH_BYTES)
                    begin
                        result.framing_error = 1'b1;
                        phase_next           = mpd_pkg::PH_HEADER;
                    end
                end
                else if (acc_next == '0)
                begin
                    result.packet_end    = 1'b1;
                    result.stored_length = count_inc;
                    phase_next           = mpd_pkg::PH_HEADER;
                end
                else
                begin
                    payload_left_next = acc_next;
                    phase_next        = mpd_pkg::PH_PAYLOAD;
                end
            end
            mpd_pkg::PH_PAYLOAD:
            begin
                result.byte_role = mpd_pkg::ROLE_PAYLOAD;
                if (stored_count_reg < buffer_size)
                begin
                    result.store_enable = 1'b1;
                    result.buffer_index = stored_count_reg;
                    stored_count_next   = count_inc;
                end
                payload_left_next = payload_left_reg - 28'd1;
                if (payload_left_next == '0)
                begin
                    result.packet_end    = 1'b1;
                    result.stored_length = stored_count_next;
                    phase_next           = mpd_pkg::PH_HEADER;
                end
            end
            default:
            begin
                // header byte, also taken for the unused phase code
                result.store_enable = 1'b1;
                stored_count_next   = 16'd1;
                acc_next            = '0;
                lbc_next            = '0;
                payload_left_next   = '0;
                type_next           = rx_byte[7:4];
                phase_next          = mpd_pkg::PH_LENGTH;
            end
        endcase

        result.packet_type        = type_next;
        result.remaining_length   = acc_next;
        result.length_field_bytes = lbc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= mpd_pkg::PH_HEADER;
            stored_count_reg <= '0;
            acc_reg          <= '0;
            lbc_reg          <= '0;
            payload_left_reg <= '0;
            type_reg         <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            stored_count_reg <= stored_count_next;
            acc_reg          <= acc_next;
            lbc_reg          <= lbc_next;
            payload_left_reg <= payload_left_next;
            type_reg         <= type_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mpd_out_stage.sv */
// ----------------------------------------------------------------------------
// mpd_out_stage
// Result register and master-side stream packing.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_valid,
    input  wire mpd_pkg::result_t res,
    output logic                  load_ready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [79:0]           m_tdata,
    output logic                  m_tlast,
    output logic [1:0]            m_tuser
);

    logic             valid_reg;
    logic             valid_next;
    mpd_pkg::result_t res_reg;

    assign load_ready = !valid_reg || m_tready;
    assign valid_next = load_ready ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && load_ready)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = res_reg.packet_end;
    assign m_tuser  = res_reg.byte_role;
    assign m_tdata  = {3'd0,
                       res_reg.framing_error,
                       res_reg.length_field_bytes,
                       res_reg.stored_length,
                       res_reg.remaining_length,
                       res_reg.packet_type,
                       res_reg.store_enable,
                       res_reg.buffer_index,
                       res_reg.byte_value};

endmodule

`default_nettype wire

/* rtl/mqtt_packet_deframer_top.sv */
// ----------------------------------------------------------------------------
// mqtt_packet_deframer_top
// Splits a received byte stream into MQTT control packets, one result per byte.
// ----------------------------------------------------------------------------
// Path: an input transfer is registered in the input stage, decoded by the core and registered in the output stage.
// Throughput: one byte per cycle while m_tready accepts results; the framing state updates once per accepted byte.
// Reset: phase back to header hunt, counters cleared, buffer_size set to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_packet_deframer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side: tdata[7:0] rx_byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: [7:0] byte_value, [23:8] buffer_index, [24] store_enable,
    // [28:25] packet_type, [56:29] remaining_length, [72:57] stored_length,
    // [75:73] length_field_bytes, [76] framing_error, [79:77] zero
    output logic [79:0]      m_tdata,
    output logic             m_tlast,   // packet_end
    output logic [1:0]       m_tuser,   // [1:0] byte_role
    // buffer_size register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic             byte_valid;
    logic [7:0]       byte_data;
    logic             load_ready;
    logic             advance;
    logic [15:0]      buffer_size_reg;
    mpd_pkg::result_t result;

    assign cfg_ready = 1'b1;
    assign advance   = byte_valid && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= mpd_pkg::BUFFER_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            buffer_size_reg <= cfg_data;
        end
    end

    mpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .advance    (advance)
    );

    mpd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .rx_byte     (byte_data),
        .buffer_size (buffer_size_reg),
        .result      (result)
    );

    mpd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (byte_valid),
        .res        (result),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
